// File: hw/rtl/mfip_pkg.sv
`timescale 1ns / 1ps

package mfip_pkg;

  // Field layout of one item on each channel.
  typedef struct packed {
    logic [7:0]         format_char;
    logic signed [31:0] arg_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  // ASCII codes the sequencer recognizes or emits.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_D   = 8'h64;
  localparam logic [7:0] CH_LC_X   = 8'h78;

  // Digit register sizing: ten BCD digits cover any 32-bit magnitude.
  localparam int MAG_W      = 32;
  localparam int BCD_DIGITS = 10;
  localparam int DIG_W      = 4 * BCD_DIGITS;
  localparam int CNT_W      = 6;

  localparam logic [CNT_W-1:0] CNT_DEC    = CNT_W'(BCD_DIGITS);
  localparam logic [CNT_W-1:0] CNT_HEX    = CNT_W'(MAG_W / 4);
  localparam logic [CNT_W-1:0] CNT_BIN    = CNT_W'(MAG_W);
  localparam logic [CNT_W-1:0] CNT_DABBLE = CNT_W'(MAG_W);

  typedef enum logic [1:0] {
    CONV_DEC,
    CONV_HEX,
    CONV_BIN,
    CONV_DOLLAR
  } conv_t;

  typedef enum logic [1:0] {
    DOP_HOLD,
    DOP_LOAD,
    DOP_DABBLE,
    DOP_SHIFT
  } dop_t;

  // Command from the sequencer to the digit unit.
  typedef struct packed {
    dop_t             op;
    conv_t            conv;
    logic [MAG_W-1:0] mag;
  } dig_cmd_t;

  // Status returned by the digit unit.
  typedef struct packed {
    logic [3:0] top_digit;
    logic       top_zero;
    logic       cnt_one;
  } dig_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PCT,
    S_ECHO,
    S_DABBLE,
    S_SKIP,
    S_SIGN,
    S_PRE0,
    S_PRE1,
    S_DIGIT
  } state_t;

  // Maps a digit value to its character from "0123456789abcdef".
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end else begin
      return CH_LC_A + d8 - 8'd10;
    end
  endfunction

endpackage

// File: hw/rtl/mfip_digit_unit.sv
`timescale 1ns / 1ps

// Shared digit engine. It converts a magnitude to BCD one bit per cycle
// (shift and add-3), and shifts the digit register left by one digit (one bit in binary
// mode) per cycle, for leading-zero removal and for emission.
module mfip_digit_unit (
  input  logic                clk,
  input  logic                rst,
  input  mfip_pkg::dig_cmd_t  cmd,
  output mfip_pkg::dig_stat_t stat
);

  logic [mfip_pkg::DIG_W-1:0] dig;
  logic [mfip_pkg::MAG_W-1:0] src;
  logic [mfip_pkg::CNT_W-1:0] cnt;
  logic                       bin;
  logic [mfip_pkg::DIG_W-1:0] adj;
  logic                       cnt_one;

  always_comb begin
    for (int i = 0; i < mfip_pkg::BCD_DIGITS; i++) begin
      if (dig[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = dig[4*i +: 4];
      end
    end
  end

  assign cnt_one = (cnt == mfip_pkg::CNT_W'(1));

  always_comb begin
    if (bin) begin
      stat.top_digit = {3'b000, dig[mfip_pkg::DIG_W-1]};
    end else begin
      stat.top_digit = dig[mfip_pkg::DIG_W-1 -: 4];
    end
    stat.top_zero = (stat.top_digit == 4'd0);
    stat.cnt_one  = cnt_one;
  end

  // Control: digit count and radix mode.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      bin <= 1'b0;
    end else begin
      case (cmd.op)
        mfip_pkg::DOP_LOAD: begin
          bin <= (cmd.conv == mfip_pkg::CONV_BIN);
          case (cmd.conv)
            mfip_pkg::CONV_HEX: cnt <= mfip_pkg::CNT_HEX;
            mfip_pkg::CONV_BIN: cnt <= mfip_pkg::CNT_BIN;
            default:            cnt <= mfip_pkg::CNT_DABBLE;
          endcase
        end
        mfip_pkg::DOP_DABBLE: begin
          cnt <= cnt_one ? mfip_pkg::CNT_DEC : cnt - mfip_pkg::CNT_W'(1);
        end
        mfip_pkg::DOP_SHIFT: begin
          cnt <= cnt - mfip_pkg::CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Payload: digit and source shift registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      mfip_pkg::DOP_LOAD: begin
        if (cmd.conv == mfip_pkg::CONV_HEX || cmd.conv == mfip_pkg::CONV_BIN) begin
          dig <= {cmd.mag, {(mfip_pkg::DIG_W - mfip_pkg::MAG_W){1'b0}}};
        end else begin
          dig <= '0;
        end
        src <= cmd.mag;
      end
      mfip_pkg::DOP_DABBLE: begin
        {dig, src} <= {adj[mfip_pkg::DIG_W-2:0], src, 1'b0};
      end
      mfip_pkg::DOP_SHIFT: begin
        if (bin) begin
          dig <= {dig[mfip_pkg::DIG_W-2:0], 1'b0};
        end else begin
          dig <= {dig[mfip_pkg::DIG_W-5:0], 4'b0000};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/mini_format_integer_printer_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Item
// --------  ---------  ---------------------  -------------------------------
// in        input      in_valid / in_ready    format_char, arg_value
// out       output     out_valid / out_ready  out_char, last_of_run
//
// An item is accepted only in the idle state, and that cycle is its first one. A plain byte or
// an unknown conversion then takes 1 cycle per emitted character; a lone percent takes no more.
// A decimal conversion first runs the BCD conversion. Every conversion then drops up
// to 9 (decimal), 7 (hex) or 31 (binary) leading zeros, one per cycle, and then emits
// 1 character per cycle (sign, prefix, digits). A stalled output holds the
// sequencer; reset (rst, synchronous) clears the percent flag and empties the output register.
module mini_format_integer_printer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfip_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output mfip_pkg::out_item_t out_item
);

  mfip_pkg::state_t    state;
  mfip_pkg::state_t    state_next;
  logic                pending;
  logic                pending_next;
  mfip_pkg::conv_t     conv;
  logic                neg;
  logic [7:0]          echo_char;
  logic                echo_after;

  // Decode of the incoming item.
  logic                in_fire;
  logic [7:0]          fc;
  logic                is_num;
  mfip_pkg::conv_t     in_conv;
  logic [31:0]         arg_raw;
  logic                arg_neg;
  logic [31:0]         arg_mag;

  // Emission and digit unit control.
  logic                emit_ok;
  logic                emit;
  mfip_pkg::out_item_t emit_item;
  mfip_pkg::dig_cmd_t  ucmd;
  mfip_pkg::dig_stat_t ustat;

  assign in_ready = (state == mfip_pkg::S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fc       = in_item.format_char;
  assign arg_raw  = in_item.arg_value;
  assign arg_neg  = arg_raw[31];
  assign arg_mag  = arg_neg ? (32'd0 - arg_raw) : arg_raw;
  assign emit_ok  = !out_valid || out_ready;

  // A conversion letter only counts when a percent sign is pending.
  always_comb begin
    is_num  = 1'b1;
    in_conv = mfip_pkg::CONV_DEC;
    case (fc)
      mfip_pkg::CH_LC_D:   in_conv = mfip_pkg::CONV_DEC;
      mfip_pkg::CH_LC_X:   in_conv = mfip_pkg::CONV_HEX;
      mfip_pkg::CH_LC_B:   in_conv = mfip_pkg::CONV_BIN;
      mfip_pkg::CH_DOLLAR: in_conv = mfip_pkg::CONV_DOLLAR;
      default:             is_num  = 1'b0;
    endcase
    if (!pending) begin
      is_num = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next   = state;
    pending_next = pending;
    case (state)
      mfip_pkg::S_IDLE: begin
        if (in_fire) begin
          if (pending) begin
            pending_next = 1'b0;
            if (is_num) begin
              if (in_conv == mfip_pkg::CONV_HEX || in_conv == mfip_pkg::CONV_BIN) begin
                state_next = mfip_pkg::S_SKIP;
              end else begin
                state_next = mfip_pkg::S_DABBLE;
              end
            end else begin
              state_next = mfip_pkg::S_PCT;
            end
          end else if (fc == mfip_pkg::CH_PCT) begin
            pending_next = 1'b1;
          end else if (fc != mfip_pkg::CH_NUL) begin
            state_next = mfip_pkg::S_ECHO;
          end
        end
      end
      mfip_pkg::S_PCT: begin
        if (emit_ok) begin
          state_next = echo_after ? mfip_pkg::S_ECHO : mfip_pkg::S_IDLE;
        end
      end
      mfip_pkg::S_ECHO: begin
        if (emit_ok) begin
          state_next = mfip_pkg::S_IDLE;
        end
      end
      mfip_pkg::S_DABBLE: begin
        if (ustat.cnt_one) begin
          state_next = mfip_pkg::S_SKIP;
        end
      end
      mfip_pkg::S_SKIP: begin
        if (!ustat.top_zero || ustat.cnt_one) begin
          if (neg) begin
            state_next = mfip_pkg::S_SIGN;
          end else if (conv == mfip_pkg::CONV_DEC) begin
            state_next = mfip_pkg::S_DIGIT;
          end else begin
            state_next = mfip_pkg::S_PRE0;
          end
        end
      end
      mfip_pkg::S_SIGN: begin
        if (emit_ok) begin
          state_next = (conv == mfip_pkg::CONV_DEC) ? mfip_pkg::S_DIGIT : mfip_pkg::S_PRE0;
        end
      end
      mfip_pkg::S_PRE0: begin
        if (emit_ok) begin
          state_next = (conv == mfip_pkg::CONV_DOLLAR) ? mfip_pkg::S_DIGIT : mfip_pkg::S_PRE1;
        end
      end
      mfip_pkg::S_PRE1: begin
        if (emit_ok) begin
          state_next = mfip_pkg::S_DIGIT;
        end
      end
      mfip_pkg::S_DIGIT: begin
        if (emit_ok && ustat.cnt_one) begin
          state_next = mfip_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mfip_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: the character to emit and the digit unit command.
  always_comb begin
    emit                  = 1'b0;
    emit_item.out_char    = mfip_pkg::CH_PCT;
    emit_item.last_of_run = 1'b0;
    ucmd.op               = mfip_pkg::DOP_HOLD;
    ucmd.conv             = in_conv;
    ucmd.mag              = arg_mag;
    case (state)
      mfip_pkg::S_IDLE: begin
        if (in_fire && is_num) begin
          ucmd.op = mfip_pkg::DOP_LOAD;
        end
      end
      mfip_pkg::S_PCT: begin
        emit                  = emit_ok;
        emit_item.out_char    = mfip_pkg::CH_PCT;
        emit_item.last_of_run = !echo_after;
      end
      mfip_pkg::S_ECHO: begin
        emit                  = emit_ok;
        emit_item.out_char    = echo_char;
        emit_item.last_of_run = 1'b1;
      end
      mfip_pkg::S_DABBLE: begin
        ucmd.op = mfip_pkg::DOP_DABBLE;
      end
      mfip_pkg::S_SKIP: begin
        if (ustat.top_zero && !ustat.cnt_one) begin
          ucmd.op = mfip_pkg::DOP_SHIFT;
        end
      end
      mfip_pkg::S_SIGN: begin
        emit               = emit_ok;
        emit_item.out_char = mfip_pkg::CH_MINUS;
      end
      mfip_pkg::S_PRE0: begin
        emit = emit_ok;
        if (conv == mfip_pkg::CONV_DOLLAR) begin
          emit_item.out_char = mfip_pkg::CH_DOLLAR;
        end else begin
          emit_item.out_char = mfip_pkg::CH_ZERO;
        end
      end
      mfip_pkg::S_PRE1: begin
        emit = emit_ok;
        if (conv == mfip_pkg::CONV_BIN) begin
          emit_item.out_char = mfip_pkg::CH_LC_B;
        end else begin
          emit_item.out_char = mfip_pkg::CH_LC_X;
        end
      end
      mfip_pkg::S_DIGIT: begin
        emit                  = emit_ok;
        emit_item.out_char    = mfip_pkg::digit_char(ustat.top_digit);
        emit_item.last_of_run = ustat.cnt_one;
        if (emit_ok) begin
          ucmd.op = mfip_pkg::DOP_SHIFT;
        end
      end
      default: begin
      end
    endcase
  end

  // The shared digit engine does the BCD conversion and all digit shifting.
  mfip_digit_unit u_digit (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ucmd),
    .stat (ustat)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mfip_pkg::S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  // Per-item context, captured when the item is accepted.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      conv       <= in_conv;
      neg        <= arg_neg;
      echo_char  <= fc;
      echo_after <= (fc != mfip_pkg::CH_NUL);
    end
  end

  // Output register: it holds one character; while it is full and the
  // consumer stalls, the sequencer waits in its emitting state.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item <= emit_item;
    end
  end

  // The final character of a run always returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    emit && emit_item.last_of_run |=> state == mfip_pkg::S_IDLE)
    else $error("last character did not end the run");

  // Any earlier character leaves more work for the same item.
  a_not_last_busy: assert property (@(posedge clk) disable iff (rst)
    emit && !emit_item.last_of_run |=> state != mfip_pkg::S_IDLE)
    else $error("run ended without a last character");

  // The pending percent flag only moves when an item is accepted.
  a_pending_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> pending == $past(pending))
    else $error("percent flag changed without an accepted item");

  // Decimal digits coming out of the BCD converter stay in range.
  a_bcd_range: assert property (@(posedge clk) disable iff (rst)
    state == mfip_pkg::S_DIGIT &&
    (conv == mfip_pkg::CONV_DEC || conv == mfip_pkg::CONV_DOLLAR)
    |-> ustat.top_digit <= 4'd9)
    else $error("decimal digit out of range");

endmodule
